### src/mtd_pkg.sv
// Shared types and constants of the mixed-type divider.
// Used by the top level and by the divider step stage; no dependencies.
`default_nettype none
package mtd_pkg;

	localparam logic [1:0] KIND_INT   = 2'd0;
	localparam logic [1:0] KIND_FLOAT = 2'd1;

	localparam logic [1:0] CFG_VALUE_IS_FLOAT   = 2'd0;
	localparam logic [1:0] CFG_DIVISOR_IS_FLOAT = 2'd1;
	localparam logic [1:0] CFG_OUTPUT_KIND      = 2'd2;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [31:0] UINT_MAX  = 32'hFFFF_FFFF;

	// operand after unpacking: value = sig / 2^31 * 2^exp
	typedef struct packed {
		logic [31:0]        sig;
		logic signed [10:0] exp;
		logic               nan;
		logic               inf;
		logic               zero;
		logic               sign;
	} op_t;

	// per-item control that travels with the divider data
	typedef struct packed {
		logic               int_mode;
		logic [1:0]         kind;
		logic               divz;
		logic               nan;
		logic               inf;
		logic               zero;
		logic               sign;
		logic signed [10:0] exp;
	} meta_t;

	// restoring divider state: remainder, numerator bits, divisor, quotient
	typedef struct packed {
		logic [31:0] r;
		logic [31:0] n;
		logic [31:0] d;
		logic [31:0] q;
	} div_t;

endpackage
`default_nettype wire

### src/mtd_div_step.sv
// One stage of the pipelined restoring divider: one quotient bit per stage.
// Depends on mtd_pkg for the divider and control types.
`default_nettype none
module mtd_div_step (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_vld,
	input  wire mtd_pkg::meta_t in_meta,
	input  wire mtd_pkg::div_t  in_div,
	output logic                out_vld,
	output mtd_pkg::meta_t      out_meta,
	output mtd_pkg::div_t       out_div
);

	logic [32:0]    trial;
	logic           ge;
	mtd_pkg::div_t  nxt;

	always_comb begin
		trial = {in_div.r, in_div.n[31]};
		ge    = trial >= {1'b0, in_div.d};
		nxt.d = in_div.d;
		nxt.n = {in_div.n[30:0], 1'b0};
		nxt.r = ge ? 32'(trial - {1'b0, in_div.d}) : trial[31:0];
		nxt.q = {in_div.q[30:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_meta <= in_meta;
			out_div  <= nxt;
		end
	end

endmodule
`default_nettype wire

### src/mixed_type_divider_core.sv
// Mixed-type divider top level: unpack, 32-stage divider, round and pack.
// Depends on mtd_pkg and mtd_div_step.
//
// Accepts one dividend/divisor beat every cycle while not stalled and returns
// one result beat per input, in order: two stages unpack and round the
// operands, a 32-stage restoring divider (one quotient bit per stage)
// divides, and three stages round, pack and convert the result. The
// whole pipeline advances together and holds when the result is not taken.
`default_nettype none
module mixed_type_divider_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      quotient,
	output logic             divide_error,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [1:0]  cfg_data
);

	localparam int Steps = 32;

	function automatic logic [5:0] lzc32(input logic [31:0] v);
		logic [5:0] n;
		n = 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) n = 6'(31 - i);
		end
		return n;
	endfunction

	function automatic mtd_pkg::op_t unpack(input logic [31:0] w, input logic isf);
		mtd_pkg::op_t       o;
		logic [7:0]         e;
		logic [31:0]        v;
		logic signed [10:0] base;
		logic [5:0]         lz;
		e = w[30:23];
		if (isf) begin
			v    = {(e != 8'd0), w[22:0], 8'd0};
			base = (e == 8'd0) ? -11'sd126 : $signed({3'b000, e}) - 11'sd127;
		end else begin
			v    = w;
			base = 11'sd31;
		end
		lz     = lzc32(v);
		o.sig  = v << lz;
		o.exp  = base - $signed({5'b00000, lz});
		o.nan  = isf && (e == 8'hFF) && (w[22:0] != 23'd0);
		o.inf  = isf && (e == 8'hFF) && (w[22:0] == 23'd0);
		o.zero = (v == 32'd0);
		o.sign = isf & w[31];
		return o;
	endfunction

	logic adv;
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	// configuration
	logic       vf_q, df_q;
	logic [1:0] kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vf_q   <= 1'b0;
			df_q   <= 1'b0;
			kind_q <= mtd_pkg::KIND_INT;
		end else if (cfg_valid) begin
			case (cfg_index)
				mtd_pkg::CFG_VALUE_IS_FLOAT:   vf_q   <= cfg_data[0];
				mtd_pkg::CFG_DIVISOR_IS_FLOAT: df_q   <= cfg_data[0];
				mtd_pkg::CFG_OUTPUT_KIND:      kind_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: unpack and normalise
	logic               v_s1, vf_s1, df_s1, divz_s1;
	logic [1:0]         kind_s1;
	logic [31:0]        a_s1, b_s1;
	mtd_pkg::op_t       opa_s1, opb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vf_s1   <= vf_q;
			df_s1   <= df_q;
			kind_s1 <= kind_q;
			a_s1    <= dividend;
			b_s1    <= divisor;
			opa_s1  <= unpack(dividend, vf_q);
			opb_s1  <= unpack(divisor, df_q);
			divz_s1 <= df_q ? (divisor[30:0] == 31'd0) : (divisor == 32'd0);
		end
	end

	// stage 2: round to 24 bits, classify, load the divider
	logic [24:0]         ma_sum, mb_sum;
	logic [23:0]         ma, mb;
	logic signed [10:0]  ea, eb;
	logic                up_a, up_b;
	mtd_pkg::meta_t      meta_c;
	mtd_pkg::div_t       div_c;

	always_comb begin
		up_a   = opa_s1.sig[7] & (opa_s1.sig[8] | (|opa_s1.sig[6:0]));
		up_b   = opb_s1.sig[7] & (opb_s1.sig[8] | (|opb_s1.sig[6:0]));
		ma_sum = {1'b0, opa_s1.sig[31:8]} + 25'(up_a);
		mb_sum = {1'b0, opb_s1.sig[31:8]} + 25'(up_b);
		ma     = ma_sum[24] ? ma_sum[24:1] : ma_sum[23:0];
		mb     = mb_sum[24] ? mb_sum[24:1] : mb_sum[23:0];
		ea     = opa_s1.exp + $signed({10'd0, ma_sum[24]});
		eb     = opb_s1.exp + $signed({10'd0, mb_sum[24]});

		meta_c.int_mode = !vf_s1 && !df_s1 && (kind_s1 == mtd_pkg::KIND_INT);
		meta_c.kind     = kind_s1;
		meta_c.divz     = divz_s1;
		meta_c.sign     = opa_s1.sign ^ opb_s1.sign;
		meta_c.nan      = opa_s1.nan | opb_s1.nan | (opa_s1.inf & opb_s1.inf);
		meta_c.inf      = !meta_c.nan & opa_s1.inf;
		meta_c.zero     = !meta_c.nan & !opa_s1.inf & (opb_s1.inf | opa_s1.zero);
		meta_c.exp      = ea - eb;

		div_c.q = 32'd0;
		if (meta_c.int_mode) begin
			div_c.r = 32'd0;
			div_c.n = a_s1;
			div_c.d = b_s1;
		end else begin
			// halve the dividend significand so the remainder starts below the divisor
			div_c.r = {9'd0, ma[23:1]};
			div_c.n = {ma[0], 31'd0};
			div_c.d = {8'd0, mb};
		end
	end

	logic           vld_sd  [0:Steps];
	mtd_pkg::meta_t meta_sd [0:Steps];
	mtd_pkg::div_t  div_sd  [0:Steps];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[0] <= 1'b0;
		end else if (adv) begin
			vld_sd[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_sd[0] <= meta_c;
			div_sd[0]  <= div_c;
		end
	end

	// stage 3: divider
	for (genvar g = 0; g < Steps; g++) begin : g_div
		mtd_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_vld   (vld_sd[g]),
			.in_meta  (meta_sd[g]),
			.in_div   (div_sd[g]),
			.out_vld  (vld_sd[g+1]),
			.out_meta (meta_sd[g+1]),
			.out_div  (div_sd[g+1])
		);
	end

	// stage 4: normalise quotient, denormalise for subnormal results
	mtd_pkg::meta_t     dm;
	mtd_pkg::div_t      dd;
	logic               nrm;
	logic [31:0]        sig4, s4;
	logic signed [10:0] eb4, amt;
	logic [5:0]         amt6;
	logic [63:0]        wide;
	logic               lost4;

	assign dm = meta_sd[Steps];
	assign dd = div_sd[Steps];

	always_comb begin
		nrm  = dd.q[31];
		sig4 = nrm ? dd.q : {dd.q[30:0], 1'b0};
		eb4  = dm.exp + 11'sd127 - (nrm ? 11'sd0 : 11'sd1);
		amt  = 11'sd1 - eb4;
		amt6 = (amt > 11'sd32) ? 6'd32 : amt[5:0];
		wide = {sig4, 32'd0} >> amt6;
		if (eb4 >= 11'sd1) begin
			s4    = sig4;
			lost4 = 1'b0;
		end else begin
			s4    = wide[63:32];
			lost4 = |wide[31:0];
		end
	end

	logic               v_s4, st_s4, sub_s4;
	logic [31:0]        word_s4;
	logic signed [10:0] e_s4;
	mtd_pkg::meta_t     meta_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= vld_sd[Steps];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s4 <= dm;
			word_s4 <= dm.int_mode ? dd.q : s4;
			st_s4   <= (dd.r != 32'd0) | lost4;
			sub_s4  <= (eb4 < 11'sd1);
			e_s4    <= (eb4 < 11'sd1) ? 11'sd0 : eb4;
		end
	end

	// stage 5: round and pack the float result
	logic               up5;
	logic [24:0]        m5;
	logic signed [10:0] ef5;
	logic [22:0]        frac5;
	logic [31:0]        word5;

	always_comb begin
		up5 = word_s4[7] & (word_s4[8] | (|word_s4[6:0]) | st_s4);
		m5  = {1'b0, word_s4[31:8]} + 25'(up5);
		if (sub_s4) begin
			ef5   = $signed({10'd0, m5[23]});
			frac5 = m5[22:0];
		end else begin
			ef5   = e_s4 + $signed({10'd0, m5[24]});
			frac5 = m5[24] ? m5[23:1] : m5[22:0];
		end
		// a zero quotient carries a meaningless exponent, so test it before overflow
		if (meta_s4.nan) begin
			word5 = mtd_pkg::CANON_NAN;
		end else if (meta_s4.inf) begin
			word5 = {meta_s4.sign, 8'hFF, 23'd0};
		end else if (meta_s4.zero) begin
			word5 = {meta_s4.sign, 31'd0};
		end else if (ef5 >= 11'sd255) begin
			word5 = {meta_s4.sign, 8'hFF, 23'd0};
		end else begin
			word5 = {meta_s4.sign, ef5[7:0], frac5};
		end
	end

	logic           v_s5;
	logic [31:0]    word_s5;
	mtd_pkg::meta_t meta_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s5 <= meta_s4;
			word_s5 <= meta_s4.int_mode ? word_s4 : word5;
		end
	end

	// stage 6: float to integer, result select
	logic [7:0]  e6;
	logic        nan6;
	logic [31:0] conv6, res6;

	always_comb begin
		e6   = word_s5[30:23];
		nan6 = (e6 == 8'hFF) && (word_s5[22:0] != 23'd0);
		if (nan6 || word_s5[31] || e6 < 8'd127) begin
			conv6 = 32'd0;
		end else if (e6 >= 8'd159) begin
			conv6 = mtd_pkg::UINT_MAX;
		end else begin
			conv6 = {1'b1, word_s5[22:0], 8'd0} >> (8'd158 - e6);
		end
		case (meta_s5.kind)
			mtd_pkg::KIND_INT:   res6 = meta_s5.int_mode ? word_s5 : conv6;
			mtd_pkg::KIND_FLOAT: res6 = word_s5;
			default:             res6 = 32'd0;
		endcase
		if (meta_s5.divz) res6 = 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quotient     <= res6;
			divide_error <= meta_s5.divz;
		end
	end

endmodule
`default_nettype wire

### src/mtd_checker.sv
// Port-level checks of the mixed-type divider and the bind that attaches them.
// Depends on mixed_type_divider_core port names only.
`default_nettype none
module mtd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] quotient,
	input wire logic        divide_error
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quotient) && $stable(divide_error))
		else $error("result beat changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_error |-> quotient == 32'd0)
		else $error("divide error with nonzero quotient");

	// input side stalls exactly when the output beat is stuck
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && in_valid |=> $stable(quotient))
		else $error("stalled pipeline moved");

endmodule

bind mixed_type_divider_core mtd_checker u_mtd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.quotient     (quotient),
	.divide_error (divide_error)
);
`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for mixed_type_divider_core: directed and random division beats
// under every operand/result configuration, checked against a bit-exact quotient predictor.
// Depends on mtd_pkg and the divider RTL only.
`timescale 1ns / 1ps
module tb_top;

	localparam logic [1:0] KIND_NONE  = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int         DRAIN_CYC  = 45;

	typedef struct {
		logic [31:0] quo;
		logic        err;
	} quo_t;

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic [31:0] dividend, divisor, quotient;
	logic        divide_error;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index, cfg_data;

	logic        num_fp, den_fp;
	logic [1:0]  res_kind;
	quo_t        quo_q[$];
	int          n_err, n_sent, n_seen, rx_hold;
	bit          tx_busy, rx_busy;

	mixed_type_divider_core dut (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ---------------- float helpers ----------------
	function automatic bit is_nan(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] != 0;
	endfunction

	function automatic real sp_to_real(logic [31:0] x);
		int          e;
		logic [23:0] sig;
		if (x[30:0] == 0) return $bitstoreal({x[31], 63'b0});
		if (x[30:23] == 0) begin
			e   = -126;
			sig = {1'b0, x[22:0]};
			while (!sig[23]) begin
				sig = sig << 1;
				e--;
			end
		end else begin
			e   = int'(x[30:23]) - 127;
			sig = {1'b1, x[22:0]};
		end
		return $bitstoreal({x[31], 11'(e + 1023), sig[22:0], 29'b0});
	endfunction

	// round a finite non-zero double to single precision, nearest-even
	function automatic logic [31:0] real_to_sp(real v);
		logic [63:0] d, m, keep, rest, half;
		int          e, sh;
		d  = $realtobits(v);
		e  = int'(d[62:52]) - 1023;
		m  = {11'b0, 1'b1, d[51:0]};
		sh = (e >= -126) ? 29 : 29 + (-126 - e);
		if (sh > 60) return {d[63], 31'b0};
		keep = m >> sh;
		rest = m & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rest > half || (rest == half && keep[0])) keep++;
		if (e >= -126) begin
			if (keep[24]) begin
				keep = keep >> 1;
				e++;
			end
			if (e > 127) return {d[63], 8'hFF, 23'b0};
			return {d[63], 8'(e + 127), keep[22:0]};
		end
		return {d[63], 31'b0} + keep[31:0];
	endfunction

	function automatic logic [31:0] uint_to_sp(logic [31:0] a);
		if (a == 0) return 32'b0;
		return real_to_sp(real'({32'b0, a}));
	endfunction

	function automatic logic [31:0] sp_to_uint(logic [31:0] x);
		logic [63:0] sig;
		int          sh;
		if (is_nan(x) || x[31] || x[30:0] == 0) return 32'b0;
		if (x[30:23] >= 8'd159) return mtd_pkg::UINT_MAX;
		if (x[30:23] < 8'd127) return 32'b0;
		sig = {40'b0, 1'b1, x[22:0]};
		sh  = int'(x[30:23]) - 150;
		return (sh >= 0) ? 32'(sig << sh) : 32'(sig >> -sh);
	endfunction

	function automatic logic [31:0] sp_divide(logic [31:0] a, logic [31:0] b);
		logic s;
		bit   a_inf, b_inf;
		s     = a[31] ^ b[31];
		a_inf = a[30:0] == 31'h7F80_0000;
		b_inf = b[30:0] == 31'h7F80_0000;
		if (is_nan(a) || is_nan(b) || (a_inf && b_inf)) return mtd_pkg::CANON_NAN;
		if (a_inf) return {s, 8'hFF, 23'b0};
		if (b_inf || a[30:0] == 0) return {s, 31'b0};
		return real_to_sp(sp_to_real(a) / sp_to_real(b));
	endfunction

	function automatic quo_t divide_expect(logic [31:0] a, logic [31:0] b);
		quo_t        r;
		logic [31:0] num_sp, den_sp;
		r.err = den_fp ? (b[30:0] == 0) : (b == 0);
		r.quo = 32'b0;
		if (r.err) return r;
		num_sp = num_fp ? a : uint_to_sp(a);
		den_sp = den_fp ? b : uint_to_sp(b);
		case (res_kind)
			mtd_pkg::KIND_INT: begin
				if (!num_fp && !den_fp) r.quo = a / b;
				else r.quo = sp_to_uint(sp_divide(num_sp, den_sp));
			end
			mtd_pkg::KIND_FLOAT: r.quo = sp_divide(num_sp, den_sp);
			default:             r.quo = 32'b0;
		endcase
		return r;
	endfunction

	// ---------------- checking ----------------
	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		n_err++;
		$display("MISMATCH %s: got %h want %h (beat %0d)", what, got, want, n_seen);
	endtask

	always @(posedge clk) begin
		quo_t w;
		if (arst_n && out_valid && out_ready) begin
			if (quo_q.size() == 0) begin
				report("unexpected beat", quotient, 32'b0);
			end else begin
				w = quo_q.pop_front();
				if (quotient !== w.quo) report("quotient", quotient, w.quo);
				if (divide_error !== w.err) report("divide_error", divide_error, w.err);
			end
			n_seen++;
		end
	end

	// ---------------- receiver ----------------
	initial begin
		int g;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 9) == 0) rx_busy = !rx_busy;
			g = rx_hold ? rx_hold : (rx_busy ? $urandom_range(0, 16) : 0);
			rx_hold = 0;
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// ---------------- sender ----------------
	task automatic send_item(logic [31:0] a, logic [31:0] b);
		int g;
		if ($urandom_range(0, 9) == 0) tx_busy = !tx_busy;
		g = tx_busy ? $urandom_range(0, 16) : 0;
		@(negedge clk);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		dividend <= a;
		divisor  <= b;
		do @(posedge clk); while (!in_ready);
		quo_q.push_back(divide_expect(a, b));
		n_sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (quo_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			mtd_pkg::CFG_VALUE_IS_FLOAT:   num_fp   = val[0];
			mtd_pkg::CFG_DIVISOR_IS_FLOAT: den_fp   = val[0];
			mtd_pkg::CFG_OUTPUT_KIND:      res_kind = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_mode(bit nf, bit df, logic [1:0] k);
		wait_drain();
		cfg_write(mtd_pkg::CFG_VALUE_IS_FLOAT, {1'b0, nf});
		cfg_write(mtd_pkg::CFG_DIVISOR_IS_FLOAT, {1'b0, df});
		cfg_write(mtd_pkg::CFG_OUTPUT_KIND, k);
	endtask

	// ---------------- operand generators ----------------
	function automatic logic [31:0] rand_int();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 20);
			1:       return 32'd1 << $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] rand_sp();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 9))
			0: r[30:0] = 31'h7F80_0000;                    // infinity
			1: r[30:23] = 8'hFF;                           // nan, or infinity
			2: r[30:23] = 8'h00;                           // subnormal
			3: r[30:0] = 31'b0;                            // signed zero
			4, 5, 6: r[30:23] = 8'(127 + $urandom_range(0, 40) - 10);
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rand_operand(bit fp);
		return fp ? rand_sp() : rand_int();
	endfunction

	// ---------------- tests ----------------
	task automatic test_integer_corners();
		set_mode(1'b0, 1'b0, mtd_pkg::KIND_INT);
		send_item(32'd100, 32'd7);
		send_item(32'hFFFF_FFFF, 32'd1);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(32'd5, 32'd0);
		send_item(32'd0, 32'd3);
		send_item(32'd3, 32'd10);
		set_mode(1'b0, 1'b0, mtd_pkg::KIND_FLOAT);
		send_item(32'hFFFF_FFFF, 32'd3);
		send_item(32'h0100_0001, 32'd1);               // rounds to even
		send_item(32'd1, 32'd0);
	endtask

	task automatic test_float_specials();
		set_mode(1'b1, 1'b1, mtd_pkg::KIND_FLOAT);
		send_item(32'h3F80_0000, 32'h8000_0000);      // divide by negative zero
		send_item(32'h7FC0_0001, 32'h3F80_0000);      // nan dividend
		send_item(32'h3F80_0000, 32'hFFC0_0000);      // nan divisor
		send_item(32'h7F80_0000, 32'h7F80_0000);
		send_item(32'h0000_0001, 32'h4000_0000);      // subnormal halved
		send_item(32'h7F7F_FFFF, 32'h0000_0001);      // overflow
		set_mode(1'b1, 1'b1, mtd_pkg::KIND_INT);
		send_item(32'hC000_0000, 32'h3F80_0000);      // negative to integer
		send_item(32'h7F80_0000, 32'h3F80_0000);      // infinity saturates
		send_item(32'h4F80_0000, 32'h3F80_0000);      // exactly 2^32
		send_item(32'h4F7F_FFFF, 32'h3F80_0000);
		send_item(32'h7FC0_0000, 32'h3F80_0000);
	endtask

	task automatic test_unsupported_kind();
		set_mode(1'b1, 1'b0, KIND_NONE);
		send_item(32'h4000_0000, 32'd2);
		send_item(32'h4000_0000, 32'd0);
		set_mode(1'b0, 1'b1, KIND_SPARE);
		send_item(32'd9, 32'h4000_0000);
		send_item(32'd9, 32'h0000_0000);
	endtask

	task automatic test_back_pressure();
		set_mode(1'b0, 1'b1, mtd_pkg::KIND_FLOAT);
		rx_hold = 300;
		tx_busy = 1'b0;
		repeat (80) send_item(rand_int(), rand_sp());
		wait_drain();
	endtask

	task automatic test_random_modes();
		bit         nf, df;
		logic [1:0] k;
		for (int p = 0; p < 16; p++) begin
			nf = p[0];
			df = p[1];
			k  = (p < 12) ? 2'(p >> 2) : 2'($urandom_range(0, 3));
			set_mode(nf, df, k);
			repeat (34) send_item(rand_operand(nf), rand_operand(df));
		end
		// a pass with fully random bits in every field
		set_mode(1'b1, 1'b1, mtd_pkg::KIND_FLOAT);
		repeat (40) send_item($urandom(), $urandom());
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		dividend  = 32'b0;
		divisor   = 32'b0;
		cfg_valid = 1'b0;
		cfg_index = mtd_pkg::CFG_VALUE_IS_FLOAT;
		cfg_data  = 2'b0;
		num_fp    = 1'b0;
		den_fp    = 1'b0;
		res_kind  = mtd_pkg::KIND_INT;
		n_err     = 0;
		n_sent    = 0;
		n_seen    = 0;
		rx_hold   = 0;
		tx_busy   = 1'b0;
		rx_busy   = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_integer_corners();
		test_float_specials();
		test_unsupported_kind();
		test_back_pressure();
		test_random_modes();
		wait_drain();

		if (quo_q.size() != 0) begin
			n_err++;
			$display("%0d expected results never arrived", quo_q.size());
		end
		$display("Sent %0d operand pairs, checked %0d results over all operand and result kinds,",
			n_sent, n_seen);
		$display("including zero, nan, infinity, subnormal and saturation corners.");
		if (n_err == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout after %0d results", n_seen);
		$display("tb_top: errors");
		$finish;
	end

endmodule
